/* src/rts_pkg.sv */
package rts_pkg;

   // Field widths of the item and result words
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 1;
   localparam int INDEX_W   = 16;
   localparam int TEXEL_W   = 32;
   localparam int COORD_W   = 16;
   localparam int CHAN_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int NUM_CHAN  = 4;

   // Operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Filter codes
   localparam logic FILTER_NEAREST = 1'b0;
   localparam logic FILTER_LINEAR  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

   typedef struct packed {
      logic               op;
      logic [INDEX_W-1:0] texel_index;
      logic [TEXEL_W-1:0] texel_rgba;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic               filter_mode;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              coord_clamped;
   } rsp_type;

   // Control that travels with each item down the pipeline
   typedef struct packed {
      logic valid;
      logic sample;
      logic clamped;
   } ctl_type;

endpackage

/* src/rts_ram.sv */
module rts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/rts_axis.sv */
module rts_axis #(
   parameter int SIZE_MAX  = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic [rts_pkg::CFG_W-1:0]     size_cfg,
   input  logic [rts_pkg::COORD_W-1:0]   coord,
   input  logic                          linear,
   output logic [$clog2(SIZE_MAX)-1:0]   idx,
   output logic [$clog2(SIZE_MAX)-1:0]   nidx,
   output logic [$clog2(SIZE_MAX+1)-1:0] size,
   output logic [FRAC_BITS-1:0]          frac,
   output logic                          over
);

   localparam int IDX_W = $clog2(SIZE_MAX);
   localparam int SZ_W  = $clog2(SIZE_MAX + 1);
   localparam int CW    = ((IDX_W + FRAC_BITS > rts_pkg::COORD_W) ?
                           IDX_W + FRAC_BITS : rts_pkg::COORD_W) + 1;
   localparam int HALF  = 1 << (FRAC_BITS - 1);

   logic [IDX_W-1:0] last;
   logic [CW-1:0]    limit;
   logic [CW-1:0]    cx;
   logic [CW-1:0]    cc;
   logic [CW-1:0]    whole;
   logic [CW-1:0]    rounded;

   // Fit the size register into 1..SIZE_MAX, keep the last index
   always_comb begin
      if (size_cfg == '0) begin
         last = '0;
      end else if (32'(size_cfg) > 32'(SIZE_MAX)) begin
         last = IDX_W'(SIZE_MAX - 1);
      end else begin
         last = IDX_W'(size_cfg - rts_pkg::CFG_W'(1));
      end
   end

   assign size = SZ_W'(last) + SZ_W'(1);

   // Clamp the coordinate to the last texel
   assign limit   = CW'(last) << FRAC_BITS;
   assign cx      = CW'(coord);
   assign over    = cx > limit;
   assign cc      = over ? limit : cx;
   assign whole   = cc >> FRAC_BITS;
   assign rounded = (cc + CW'(HALF)) >> FRAC_BITS;

   // Truncate for linear, round to nearest otherwise
   always_comb begin
      if (linear) begin
         idx  = whole[IDX_W-1:0];
         frac = cc[FRAC_BITS-1:0];
      end else begin
         frac = '0;
         if (rounded > CW'(last)) begin
            idx = last;
         end else begin
            idx = rounded[IDX_W-1:0];
         end
      end
   end

   // Neighbor stops at the image edge
   assign nidx = (idx == last) ? idx : idx + IDX_W'(1);

endmodule

/* src/rts_addr.sv */
module rts_addr #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     accept,
   input  rts_pkg::req_type                         req,
   input  logic [rts_pkg::CFG_W-1:0]                width_cfg,
   input  logic [rts_pkg::CFG_W-1:0]                height_cfg,
   output rts_pkg::ctl_type                         ctl_s3,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  base_addr,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  right_addr,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  down_addr,
   output logic [FRAC_BITS-1:0]                     fx_s3,
   output logic [FRAC_BITS-1:0]                     fy_s3,
   output logic                                     wr_en,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  wr_addr,
   output logic [rts_pkg::TEXEL_W-1:0]              wr_data
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
   localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);
   localparam int IW     = ((ADDR_W > rts_pkg::INDEX_W) ? ADDR_W : rts_pkg::INDEX_W) + 1;

   // Stage 1: registered item
   logic             valid1_ff;
   rts_pkg::req_type req1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= accept;
      end
      req1_ff <= req;
   end

   logic                 linear;
   logic [COL_W-1:0]     col_in;
   logic [COL_W-1:0]     ncol_in;
   logic [ROW_W-1:0]     row_in;
   logic [ROW_W-1:0]     nrow_in;
   logic [WSZ_W-1:0]     w_in;
   logic [HSZ_W-1:0]     h_unused;
   logic [FRAC_BITS-1:0] fx_in;
   logic [FRAC_BITS-1:0] fy_in;
   logic                 over_x;
   logic                 over_y;
   logic [IW-1:0]        idx_ext;
   rts_pkg::ctl_type     ctl2_in;

   assign linear = req1_ff.filter_mode == rts_pkg::FILTER_LINEAR;

   rts_axis #(.SIZE_MAX(MAX_WIDTH), .FRAC_BITS(FRAC_BITS)) u_axis_x (
      .size_cfg (width_cfg),
      .coord    (req1_ff.coord_x),
      .linear   (linear),
      .idx      (col_in),
      .nidx     (ncol_in),
      .size     (w_in),
      .frac     (fx_in),
      .over     (over_x)
   );

   rts_axis #(.SIZE_MAX(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)) u_axis_y (
      .size_cfg (height_cfg),
      .coord    (req1_ff.coord_y),
      .linear   (linear),
      .idx      (row_in),
      .nidx     (nrow_in),
      .size     (h_unused),
      .frac     (fy_in),
      .over     (over_y)
   );

   assign idx_ext         = IW'(req1_ff.texel_index);
   assign ctl2_in.valid   = valid1_ff;
   assign ctl2_in.sample  = req1_ff.op == rts_pkg::OP_SAMPLE;
   assign ctl2_in.clamped = over_x | over_y | (h_unused == '0);

   // Stage 2: texel coordinates
   rts_pkg::ctl_type            ctl2_ff;
   logic [COL_W-1:0]            col2_ff;
   logic [COL_W-1:0]            ncol2_ff;
   logic [ROW_W-1:0]            row2_ff;
   logic [ROW_W-1:0]            nrow2_ff;
   logic [WSZ_W-1:0]            w2_ff;
   logic [FRAC_BITS-1:0]        fx2_ff;
   logic [FRAC_BITS-1:0]        fy2_ff;
   logic                        wok2_ff;
   logic [ADDR_W-1:0]           waddr2_ff;
   logic [rts_pkg::TEXEL_W-1:0] rgba2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else begin
         ctl2_ff <= ctl2_in;
      end
      col2_ff   <= col_in;
      ncol2_ff  <= ncol_in;
      row2_ff   <= row_in;
      nrow2_ff  <= nrow_in;
      w2_ff     <= w_in;
      fx2_ff    <= fx_in;
      fy2_ff    <= fy_in;
      wok2_ff   <= idx_ext < IW'(DEPTH);
      waddr2_ff <= idx_ext[ADDR_W-1:0];
      rgba2_ff  <= req1_ff.texel_rgba;
   end

   // Row offsets: one multiply per row read
   logic [ADDR_W-1:0] roff_in;
   logic [ADDR_W-1:0] doff_in;

   assign roff_in = ADDR_W'(row2_ff * w2_ff);
   assign doff_in = ADDR_W'(nrow2_ff * w2_ff);

   // Stage 3: row offsets
   rts_pkg::ctl_type            ctl3_ff;
   logic [ADDR_W-1:0]           roff3_ff;
   logic [ADDR_W-1:0]           doff3_ff;
   logic [COL_W-1:0]            col3_ff;
   logic [COL_W-1:0]            ncol3_ff;
   logic [FRAC_BITS-1:0]        fx3_ff;
   logic [FRAC_BITS-1:0]        fy3_ff;
   logic                        wok3_ff;
   logic [ADDR_W-1:0]           waddr3_ff;
   logic [rts_pkg::TEXEL_W-1:0] rgba3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else begin
         ctl3_ff <= ctl2_ff;
      end
      roff3_ff  <= roff_in;
      doff3_ff  <= doff_in;
      col3_ff   <= col2_ff;
      ncol3_ff  <= ncol2_ff;
      fx3_ff    <= fx2_ff;
      fy3_ff    <= fy2_ff;
      wok3_ff   <= wok2_ff;
      waddr3_ff <= waddr2_ff;
      rgba3_ff  <= rgba2_ff;
   end

   // Final addresses; loads write in this same stage to keep item order
   assign ctl_s3     = ctl3_ff;
   assign base_addr  = roff3_ff + ADDR_W'(col3_ff);
   assign right_addr = roff3_ff + ADDR_W'(ncol3_ff);
   assign down_addr  = doff3_ff + ADDR_W'(col3_ff);
   assign fx_s3      = fx3_ff;
   assign fy_s3      = fy3_ff;
   assign wr_en      = ctl3_ff.valid && !ctl3_ff.sample && wok3_ff;
   assign wr_addr    = waddr3_ff;
   assign wr_data    = rgba3_ff;

endmodule

/* src/rts_blend.sv */
module rts_blend #(
   parameter int FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rts_pkg::ctl_type            ctl_s3,
   input  logic [FRAC_BITS-1:0]        fx_s3,
   input  logic [FRAC_BITS-1:0]        fy_s3,
   input  logic [rts_pkg::TEXEL_W-1:0] base_texel,
   input  logic [rts_pkg::TEXEL_W-1:0] right_texel,
   input  logic [rts_pkg::TEXEL_W-1:0] down_texel,
   output logic                        rsp_valid,
   output rts_pkg::rsp_type            rsp_data
);

   localparam int BW    = rts_pkg::BYTE_W;
   localparam int NC    = rts_pkg::NUM_CHAN;
   localparam int WB_W  = FRAC_BITS + 2;
   localparam int PB_W  = BW + WB_W;
   localparam int PF_W  = BW + FRAC_BITS;
   localparam int SUM_W = PB_W + 1;

   // Stage 4: align side data with the memory read
   rts_pkg::ctl_type     ctl4_ff;
   logic [FRAC_BITS-1:0] fx4_ff;
   logic [FRAC_BITS-1:0] fy4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
      end else begin
         ctl4_ff <= ctl_s3;
      end
      fx4_ff <= fx_s3;
      fy4_ff <= fy_s3;
   end

   // Weighted products; a neighbor with zero weight is dropped
   logic [WB_W-1:0]            wb;
   logic [rts_pkg::TEXEL_W-1:0] right_used;
   logic [rts_pkg::TEXEL_W-1:0] down_used;
   logic [PB_W-1:0]            pb_in [NC];
   logic [PF_W-1:0]            pr_in [NC];
   logic [PF_W-1:0]            pd_in [NC];

   assign wb = WB_W'(2 << FRAC_BITS) - WB_W'(fx4_ff) - WB_W'(fy4_ff);
   assign right_used = (fx4_ff == '0) ? '0 : right_texel;
   assign down_used  = (fy4_ff == '0) ? '0 : down_texel;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         pb_in[c] = PB_W'(base_texel[BW*c +: BW]) * wb;
         pr_in[c] = PF_W'(right_used[BW*c +: BW]) * PF_W'(fx4_ff);
         pd_in[c] = PF_W'(down_used[BW*c +: BW]) * PF_W'(fy4_ff);
      end
   end

   // Stage 5: products
   rts_pkg::ctl_type ctl5_ff;
   logic [PB_W-1:0]  pb5_ff [NC];
   logic [PF_W-1:0]  pr5_ff [NC];
   logic [PF_W-1:0]  pd5_ff [NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff <= '0;
      end else begin
         ctl5_ff <= ctl4_ff;
      end
      pb5_ff <= pb_in;
      pr5_ff <= pr_in;
      pd5_ff <= pd_in;
   end

   // Sum, round half up, keep the low channel bits
   logic [SUM_W-1:0]          sum [NC];
   logic [rts_pkg::CHAN_W-1:0] chan [NC];
   rts_pkg::rsp_type          rsp_in;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         sum[c]  = SUM_W'(pb5_ff[c]) + SUM_W'(pr5_ff[c]) + SUM_W'(pd5_ff[c]) + SUM_W'(1);
         chan[c] = rts_pkg::CHAN_W'(sum[c] >> 1);
      end
      rsp_in.red           = chan[0];
      rsp_in.green         = chan[1];
      rsp_in.blue          = chan[2];
      rsp_in.alpha         = chan[3];
      rsp_in.coord_clamped = ctl5_ff.clamped;
   end

   // Output register: strobe for sample items only
   logic             rsp_valid_ff;
   rts_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl5_ff.valid && ctl5_ff.sample;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/rgba_texel_sampler_core.sv */
// RGBA texel sampler. Load items write one texel into the image store and
// give no result; sample items read the image at 8.8 coordinates with
// nearest or linear filtering and give one result. One item is taken every
// clock cycle, with no gaps: busy is high only in reset and the cycle after.
// A sample result appears on the rsp ports, strobed by rsp_valid for one
// cycle, and results leave in item order; the receiver has no way to stall
// them. The pipeline steps are coordinate clamp, row multiply, address add
// with memory read, weight multiply, sum and round. The image store is kept
// in three copies so the base, right and lower texels are read together;
// a load writes all three at the same pipeline stage where samples read,
// so a sample sees every load accepted before it. Texels never loaded read
// as unknown. Write image_width and image_height only while no item is in
// flight.
module rgba_texel_sampler_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  rts_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output rts_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [rts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rts_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   // Hold off items in the cycle after reset
   logic busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   logic accept;
   assign accept = start && !busy_ff;

   // Size registers
   logic [rts_pkg::CFG_W-1:0] width_ff;
   logic [rts_pkg::CFG_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rts_pkg::SIZE_RESET;
         height_ff <= rts_pkg::SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rts_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            rts_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Address pipeline
   rts_pkg::ctl_type            ctl_s3;
   logic [ADDR_W-1:0]           base_addr;
   logic [ADDR_W-1:0]           right_addr;
   logic [ADDR_W-1:0]           down_addr;
   logic [FRAC_BITS-1:0]        fx_s3;
   logic [FRAC_BITS-1:0]        fy_s3;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [rts_pkg::TEXEL_W-1:0] wr_data;

   rts_addr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_addr (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .width_cfg  (width_ff),
      .height_cfg (height_ff),
      .ctl_s3     (ctl_s3),
      .base_addr  (base_addr),
      .right_addr (right_addr),
      .down_addr  (down_addr),
      .fx_s3      (fx_s3),
      .fy_s3      (fy_s3),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   // Three copies of the image store, one read port each
   logic [rts_pkg::TEXEL_W-1:0] base_texel;
   logic [rts_pkg::TEXEL_W-1:0] right_texel;
   logic [rts_pkg::TEXEL_W-1:0] down_texel;

   rts_ram #(.WIDTH(rts_pkg::TEXEL_W), .DEPTH(DEPTH)) u_ram_base (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (base_addr),
      .rdata (base_texel)
   );

   rts_ram #(.WIDTH(rts_pkg::TEXEL_W), .DEPTH(DEPTH)) u_ram_right (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (right_addr),
      .rdata (right_texel)
   );

   rts_ram #(.WIDTH(rts_pkg::TEXEL_W), .DEPTH(DEPTH)) u_ram_down (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (down_addr),
      .rdata (down_texel)
   );

   // Filter pipeline
   rts_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock       (clock),
      .reset       (reset),
      .ctl_s3      (ctl_s3),
      .fx_s3       (fx_s3),
      .fy_s3       (fy_s3),
      .base_texel  (base_texel),
      .right_texel (right_texel),
      .down_texel  (down_texel),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // Checks
   logic accept_sample;
   logic accept_load;
   assign accept_sample = accept && req_data.op == rts_pkg::OP_SAMPLE;
   assign accept_load   = accept && req_data.op == rts_pkg::OP_LOAD;

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (rsp_valid == $past(accept_sample, 6)))
      else $error("result strobe does not match a sample accepted five edges earlier");

   a_write_from_load: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> $past(accept_load, 3))
      else $error("store written without a load item at the write stage");

   a_nearest_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_data.filter_mode == rts_pkg::FILTER_NEAREST, 6)
      |-> (rsp_data.red[FRAC_BITS-1:0] == '0 && rsp_data.alpha[FRAC_BITS-1:0] == '0))
      else $error("nearest result carries fraction bits");

   a_origin_unclamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_data.coord_x == '0 && req_data.coord_y == '0, 6)
      |-> !rsp_data.coord_clamped)
      else $error("sample at the origin flagged as clamped");

endmodule
